// ===== hw/rtl/dbpt_pkg.sv =====
// Shared types and constants for the button debounce and press timer.
package dbpt_pkg;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DurW     = 32;
  localparam int unsigned CountW   = 5;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE_TICKS = 1'b0,
    REG_MIN_PRESS_MS   = 1'b1
  } cfg_reg_e;

  localparam logic [CfgDataW-1:0] DebounceTicksRst = 16'd10;
  localparam logic [CfgDataW-1:0] MinPressMsRst    = 16'd10;

  // Result fields known at issue time; duration is replaced by RAM data on a pop.
  typedef struct packed {
    logic [DurW-1:0]   duration;
    logic              use_ram;
    logic              pressed;
    logic [CountW-1:0] queue_count;
  } res_meta_t;

endpackage

// ===== hw/rtl/dbpt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dbpt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 20,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/dbpt_ctrl.sv =====
// Debounce, held-time counter, config registers and duration queue pointers.
module dbpt_ctrl #(
  parameter int unsigned QueueDepth = 20,
  parameter int unsigned IdxW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  dbpt_pkg::kind_e               kind_i,
  input  logic                          pin_level_i,
  input  logic                          cfg_we_i,
  input  logic [dbpt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dbpt_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                          ram_we_o,
  output logic [IdxW-1:0]               ram_waddr_o,
  output logic [dbpt_pkg::DurW-1:0]     ram_wdata_o,
  output logic                          ram_re_o,
  output logic [IdxW-1:0]               ram_raddr_o,
  output dbpt_pkg::res_meta_t           meta_o
);
  import dbpt_pkg::*;

  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(QueueDepth - 1);

  logic [CfgDataW-1:0] debounce_q, min_press_q;
  logic                prev_q, prev_d;
  logic                stable_q, stable_d;
  logic [15:0]         settle_q, settle_d;
  logic                armed_q, armed_d;
  logic                held_q, held_d;
  logic [DurW-1:0]     held_time_q, held_time_d;
  logic [IdxW-1:0]     rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]     wr_idx_q, wr_idx_d;
  logic [CntW-1:0]     fill_q, fill_d;

  logic [15:0]         settle_inc;
  logic [DurW-1:0]     held_time_inc;

  assign settle_inc    = settle_q + 16'd1;
  assign held_time_inc = (held_q && (held_time_q != '1)) ? held_time_q + DurW'(1) : held_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= DebounceTicksRst;
      min_press_q <= MinPressMsRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DEBOUNCE_TICKS: debounce_q  <= cfg_data_i;
        REG_MIN_PRESS_MS:   min_press_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= 1'b1;
      stable_q    <= 1'b1;
      settle_q    <= '0;
      armed_q     <= 1'b0;
      held_q      <= 1'b0;
      held_time_q <= '0;
      rd_idx_q    <= '0;
      wr_idx_q    <= '0;
      fill_q      <= '0;
    end else begin
      prev_q      <= prev_d;
      stable_q    <= stable_d;
      settle_q    <= settle_d;
      armed_q     <= armed_d;
      held_q      <= held_d;
      held_time_q <= held_time_d;
      rd_idx_q    <= rd_idx_d;
      wr_idx_q    <= wr_idx_d;
      fill_q      <= fill_d;
    end
  end

  always_comb begin
    prev_d           = prev_q;
    stable_d         = stable_q;
    settle_d         = settle_q;
    armed_d          = armed_q;
    held_d           = held_q;
    held_time_d      = held_time_q;
    rd_idx_d         = rd_idx_q;
    wr_idx_d         = wr_idx_q;
    fill_d           = fill_q;
    ram_we_o         = 1'b0;
    ram_re_o         = 1'b0;
    meta_o.duration  = '0;
    meta_o.use_ram   = 1'b0;
    if (accept_i) begin
      case (kind_i)
        KIND_TICK: begin
          held_time_d = held_time_inc;
          if (pin_level_i != prev_q) begin
            // any edge restarts the settle window
            prev_d   = pin_level_i;
            settle_d = '0;
            armed_d  = 1'b1;
          end else if (armed_q) begin
            if (settle_inc >= debounce_q) begin
              armed_d  = 1'b0;
              settle_d = '0;
              if (pin_level_i != stable_q) begin
                stable_d = pin_level_i;
                if (!pin_level_i) begin
                  if (!held_q) begin
                    held_d      = 1'b1;
                    held_time_d = '0;
                  end
                end else if (held_q) begin
                  held_d = 1'b0;
                  // queue the press if long enough; drop it when full
                  if ((held_time_inc >= DurW'(min_press_q)) && (fill_q < FullCnt)) begin
                    ram_we_o = 1'b1;
                    wr_idx_d = (wr_idx_q == LastIdx) ? '0 : wr_idx_q + IdxW'(1);
                    fill_d   = fill_q + CntW'(1);
                  end
                end
              end
            end else begin
              settle_d = settle_inc;
            end
          end
        end
        KIND_POP: begin
          if (fill_q != '0) begin
            ram_re_o       = 1'b1;
            meta_o.use_ram = 1'b1;
            rd_idx_d       = (rd_idx_q == LastIdx) ? '0 : rd_idx_q + IdxW'(1);
            fill_d         = fill_q - CntW'(1);
          end else if (held_q) begin
            meta_o.duration = held_time_q;
          end
        end
        KIND_CLEAR: begin
          fill_d   = '0;
          rd_idx_d = '0;
          wr_idx_d = '0;
        end
        default: ;
      endcase
    end
    meta_o.pressed     = held_d;
    meta_o.queue_count = CountW'(fill_d);
  end

  assign ram_waddr_o        = wr_idx_q;
  assign ram_wdata_o        = held_time_inc;
  assign ram_raddr_o        = rd_idx_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FullCnt) else $error("queue fill exceeds depth");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (kind_i == KIND_CLEAR) |=> (fill_q == '0) && (rd_idx_q == '0))
    else $error("clear did not empty the queue");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (kind_i == KIND_POP) && (fill_q != '0) |=> fill_q == $past(fill_q) - CntW'(1))
    else $error("pop did not drain one entry");

  a_idle_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !armed_q |-> settle_q == '0) else $error("settle count running while disarmed");
`endif

endmodule

// ===== hw/rtl/dbpt_out_stage.sv =====
// Issue stage aligned with the RAM read, followed by the result register.
module dbpt_out_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      take_i,
  input  dbpt_pkg::res_meta_t       meta_i,
  input  logic [dbpt_pkg::DurW-1:0] rdata_i,
  output logic                      ready_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output dbpt_pkg::res_meta_t       out_o
);
  import dbpt_pkg::*;

  logic      s1_valid_q, s1_valid_d;
  res_meta_t s1_meta_q;
  logic      out_valid_q, out_valid_d;
  res_meta_t out_q, out_d;
  logic      advance;

  assign advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign ready_o = !s1_valid_q || advance;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      out_valid_d = 1'b1;
      out_d       = s1_meta_q;
      // popped entries take their duration from the registered RAM read launched at issue
      if (s1_meta_q.use_ram) begin
        out_d.duration = rdata_i;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (take_i) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      s1_meta_q <= meta_i;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q))
    else $error("stalled result changed");

  a_take_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |-> ready_o) else $error("item taken while issue stage blocked");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q) else $error("advanced item lost");
`endif

endmodule

// ===== hw/rtl/button_debounce_press_timer.sv =====
// Debounced active-low button with press-duration queue: top level.
// One item (tick, pop or clear) is taken every cycle while in_ready_o is high;
// its result passes the issue stage and then the result register, a popped
// duration coming from the registered read of the duration RAM. An issue stage
// and a result register let a new item be taken while a finished result waits
// for out_ready_i. Config writes are taken every cycle (cfg_ready_o is tied high).
module button_debounce_press_timer #(
  parameter int unsigned QueueDepth = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    kind_i,
  input  logic                          pin_level_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dbpt_pkg::DurW-1:0]     duration_o,
  output logic                          popped_valid_o,
  output logic                          pressed_o,
  output logic [dbpt_pkg::CountW-1:0]   queue_count_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dbpt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dbpt_pkg::CfgDataW-1:0] cfg_data_i
);
  import dbpt_pkg::*;

  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  logic            accept;
  logic            stage_ready;
  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  logic [DurW-1:0] ram_wdata, ram_rdata;
  res_meta_t       issue_meta, out_meta;

  assign in_ready_o  = stage_ready;
  assign accept      = in_valid_i && stage_ready;
  assign cfg_ready_o = 1'b1;

  dbpt_ctrl #(
    .QueueDepth(QueueDepth),
    .IdxW      (IdxW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .kind_i     (kind_e'(kind_i)),
    .pin_level_i(pin_level_i),
    .cfg_we_i   (cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .meta_o     (issue_meta)
  );

  dbpt_ram #(
    .Width(DurW),
    .Depth(QueueDepth),
    .AddrW(IdxW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  dbpt_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (accept),
    .meta_i     (issue_meta),
    .rdata_i    (ram_rdata),
    .ready_o    (stage_ready),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_meta)
  );

  assign duration_o     = out_meta.duration;
  assign popped_valid_o = out_meta.use_ram;
  assign pressed_o      = out_meta.pressed;
  assign queue_count_o  = out_meta.queue_count;

endmodule

// ===== bench/tb.sv =====
// Testbench for the debounced push button with press-duration queue.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dbpt_pkg::*;

  localparam int unsigned QueueDepth = 20;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam logic [1:0]  KindUnused = 2'd3;

  typedef struct {
    logic [1:0] kind;
    logic       pin;
  } button_event_t;

  typedef struct packed {
    logic [DurW-1:0]   duration;
    logic              popped_valid;
    logic              pressed;
    logic [CountW-1:0] queue_count;
  } press_report_t;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_ready_o;
  logic [1:0]          kind        = KIND_TICK;
  logic                pin_level   = 1'b1;
  logic                out_valid_o;
  logic                out_ready   = 1'b0;
  logic [DurW-1:0]     duration_o;
  logic                popped_valid_o;
  logic                pressed_o;
  logic [CountW-1:0]   queue_count_o;
  logic                cfg_valid   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index   = '0;
  logic [CfgDataW-1:0] cfg_data    = '0;

  button_debounce_press_timer #(
    .QueueDepth(QueueDepth)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind),
    .pin_level_i   (pin_level),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .duration_o    (duration_o),
    .popped_valid_o(popped_valid_o),
    .pressed_o     (pressed_o),
    .queue_count_o (queue_count_o),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  // Button model state and register copies
  logic [CfgDataW-1:0] debounce_cfg  = DebounceTicksRst;
  logic [CfgDataW-1:0] min_press_cfg = MinPressMsRst;
  logic                last_pin       = 1'b1;
  logic                settled_pin    = 1'b1;
  int unsigned         quiet_ticks    = 0;
  logic                settle_pending = 1'b0;
  logic                is_held        = 1'b0;
  logic [DurW-1:0]     held_ms        = '0;
  logic [DurW-1:0]     dur_store [QueueDepth];
  logic [PtrW-1:0]     rd_ptr         = '0;
  logic [PtrW-1:0]     wr_ptr         = '0;
  int unsigned         dur_fill       = 0;

  button_event_t button_events[$];
  press_report_t expected_reports[$];
  int unsigned   error_count   = 0;
  int unsigned   queued_events = 0;
  int unsigned   reports_seen  = 0;
  logic          in_fire       = 1'b0;
  bit            gaps_on       = 1'b1;
  int unsigned   in_gap_left   = 0;
  int unsigned   in_calm_left  = 0;
  int unsigned   out_gap_left  = 0;
  int unsigned   long_hold_left = 0;
  bit            long_hold_done = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic press_report_t predict_report(logic [1:0] k, logic lvl);
    press_report_t rep;
    rep = '0;
    case (k)
      KIND_TICK: begin
        if (is_held && held_ms != '1) held_ms++;
        if (lvl != last_pin) begin
          last_pin       = lvl;
          quiet_ticks    = 0;
          settle_pending = 1'b1;
        end else if (settle_pending) begin
          quiet_ticks++;
          if (quiet_ticks >= 32'(debounce_cfg)) begin
            settle_pending = 1'b0;
            quiet_ticks    = 0;
            if (lvl != settled_pin) begin
              settled_pin = lvl;
              if (!lvl) begin
                if (!is_held) begin
                  is_held = 1'b1;
                  held_ms = '0;
                end
              end else if (is_held) begin
                is_held = 1'b0;
                if (held_ms >= DurW'(min_press_cfg) && dur_fill < QueueDepth) begin
                  dur_store[wr_ptr] = held_ms;
                  wr_ptr = (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + PtrW'(1);
                  dur_fill++;
                end
              end
            end
          end
        end
      end
      KIND_POP: begin
        if (dur_fill > 0) begin
          rep.duration     = dur_store[rd_ptr];
          rep.popped_valid = 1'b1;
          rd_ptr = (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + PtrW'(1);
          dur_fill--;
        end else if (is_held) begin
          rep.duration = held_ms;
        end
      end
      KIND_CLEAR: begin
        dur_fill = 0;
        rd_ptr   = '0;
        wr_ptr   = '0;
      end
      default: ;
    endcase
    rep.pressed     = is_held;
    rep.queue_count = dur_fill[CountW-1:0];
    return rep;
  endfunction

  // Sample results, registers and input transfers; check before predicting.
  always @(posedge clk_i) begin
    press_report_t exp_rep;
    in_fire <= in_valid && in_ready_o;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        reports_seen++;
        if (expected_reports.size() == 0) begin
          error_count++;
          $display("%0t: result with nothing expected, duration %0d", $time, duration_o);
        end else begin
          exp_rep = expected_reports.pop_front();
          if (duration_o !== exp_rep.duration) begin
            error_count++;
            $display("%0t: duration expected %0d actual %0d",
                     $time, exp_rep.duration, duration_o);
          end
          if (popped_valid_o !== exp_rep.popped_valid) begin
            error_count++;
            $display("%0t: popped_valid expected %0b actual %0b",
                     $time, exp_rep.popped_valid, popped_valid_o);
          end
          if (pressed_o !== exp_rep.pressed) begin
            error_count++;
            $display("%0t: pressed expected %0b actual %0b",
                     $time, exp_rep.pressed, pressed_o);
          end
          if (queue_count_o !== exp_rep.queue_count) begin
            error_count++;
            $display("%0t: queue_count expected %0d actual %0d",
                     $time, exp_rep.queue_count, queue_count_o);
          end
        end
      end
      if (cfg_valid && cfg_ready_o) begin
        case (cfg_index)
          REG_DEBOUNCE_TICKS: debounce_cfg  = cfg_data;
          REG_MIN_PRESS_MS:   min_press_cfg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready_o) expected_reports.push_back(predict_report(kind, pin_level));
    end
  end

  function automatic int unsigned pick_in_gap();
    int unsigned r;
    if (in_calm_left > 0) begin
      in_calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      in_calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Event driver: hold each event until its transfer, then maybe idle.
  always @(negedge clk_i) begin
    button_event_t ev;
    if (!in_valid || in_fire) begin
      if (in_valid && gaps_on) in_gap_left = pick_in_gap();
      if (in_gap_left > 0) begin
        in_gap_left--;
        in_valid <= 1'b0;
      end else if (button_events.size() > 0) begin
        ev = button_events.pop_front();
        in_valid  <= 1'b1;
        kind      <= ev.kind;
        pin_level <= ev.pin;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off to back up the block.
  always @(negedge clk_i) begin
    int unsigned r;
    if (long_hold_left > 0) begin
      long_hold_left--;
      out_ready <= 1'b0;
    end else if (!long_hold_done && gaps_on && reports_seen >= 250) begin
      long_hold_done = 1'b1;
      long_hold_left = 120;
      out_ready <= 1'b0;
    end else if (!gaps_on) begin
      out_ready <= 1'b1;
    end else if (out_gap_left > 0) begin
      out_gap_left--;
      out_ready <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        out_gap_left = $urandom_range(8, 30);
        out_ready <= 1'b0;
      end else if (r < 25) begin
        out_gap_left = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic add_event(logic [1:0] k, logic lvl);
    button_events.push_back('{kind: k, pin: lvl});
    if (k != KindUnused) queued_events++;
  endtask

  function automatic int unsigned run_len(int unsigned db);
    if ($urandom_range(0, 9) == 0) return $urandom_range(1, db);
    return db + 1 + $urandom_range(0, 12);
  endfunction

  // One press: bounce, hold low, bounce, hold high; pops now and then.
  task automatic add_press(int unsigned db);
    int unsigned low_len;
    int unsigned high_len;
    low_len  = run_len(db);
    high_len = run_len(db);
    repeat ($urandom_range(0, 3)) add_event(KIND_TICK, 1'($urandom_range(0, 1)));
    repeat (low_len) begin
      add_event(KIND_TICK, 1'b0);
      if ($urandom_range(0, 19) == 0) add_event(KIND_POP, 1'($urandom_range(0, 1)));
    end
    repeat ($urandom_range(0, 3)) add_event(KIND_TICK, 1'($urandom_range(0, 1)));
    repeat (high_len) add_event(KIND_TICK, 1'b1);
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) add_event(KIND_POP, 1'($urandom_range(0, 1)));
  endtask

  task automatic add_random(int unsigned count, int unsigned db);
    int unsigned goal;
    int unsigned r;
    goal = queued_events + count;
    while (queued_events < goal) begin
      r = $urandom_range(0, 99);
      if (r < 65) add_press(db);
      else if (r < 80)
        repeat ($urandom_range(1, 5)) add_event(KIND_TICK, 1'($urandom_range(0, 1)));
      else if (r < 93)
        repeat ($urandom_range(1, 3)) add_event(KIND_POP, 1'($urandom_range(0, 1)));
      else if (r < 97) add_event(KIND_CLEAR, 1'($urandom_range(0, 1)));
      else add_event(KindUnused, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic wait_idle();
    while (button_events.size() > 0 || in_valid || expected_reports.size() > 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset register values; settle released and empty the queue at the end.
    add_random(40, 10);
    repeat (12) add_event(KIND_TICK, 1'b1);
    add_event(KIND_CLEAR, 1'b0);
    wait_idle();

    // Directed: empty pops, unused kind, bounce while held, release, clear.
    write_reg(REG_DEBOUNCE_TICKS, 16'd2);
    write_reg(REG_MIN_PRESS_MS, 16'd0);
    add_event(KIND_POP, 1'b1);
    add_event(KindUnused, 1'b0);
    repeat (3) add_event(KIND_TICK, 1'b0);
    add_event(KIND_POP, 1'b0);
    add_event(KIND_TICK, 1'b1);
    repeat (3) add_event(KIND_TICK, 1'b0);
    repeat (3) add_event(KIND_TICK, 1'b1);
    add_event(KIND_POP, 1'b1);
    add_event(KIND_POP, 1'b0);
    repeat (3) add_event(KIND_TICK, 1'b0);
    repeat (3) add_event(KIND_TICK, 1'b1);
    add_event(KIND_CLEAR, 1'b1);
    add_event(KIND_POP, 1'b1);
    add_event(KindUnused, 1'b1);
    wait_idle();

    // Overfill the queue, then drain it past empty.
    write_reg(REG_DEBOUNCE_TICKS, 16'd1);
    repeat (24) begin
      repeat (2) add_event(KIND_TICK, 1'b0);
      repeat (2) add_event(KIND_TICK, 1'b1);
    end
    repeat (22) add_event(KIND_POP, 1'($urandom_range(0, 1)));
    add_random(80, 1);
    wait_idle();

    write_reg(REG_DEBOUNCE_TICKS, 16'd3);
    write_reg(REG_MIN_PRESS_MS, 16'd5);
    add_random(70, 3);
    wait_idle();

    // Zero debounce behaves as one.
    write_reg(REG_DEBOUNCE_TICKS, 16'd0);
    write_reg(REG_MIN_PRESS_MS, 16'd1);
    add_random(80, 1);
    wait_idle();

    write_reg(REG_DEBOUNCE_TICKS, 16'd2);
    write_reg(REG_MIN_PRESS_MS, 16'hFFFF);
    add_random(60, 2);
    repeat (4) add_event(KIND_TICK, 1'b1);
    wait_idle();

    // Long settle window, back to back.
    gaps_on = 1'b0;
    write_reg(REG_DEBOUNCE_TICKS, 16'd20);
    repeat (21) add_event(KIND_TICK, 1'b0);
    add_event(KIND_POP, 1'b0);
    repeat (20) add_event(KIND_TICK, 1'b0);
    add_event(KIND_POP, 1'b1);
    wait_idle();
    write_reg(REG_DEBOUNCE_TICKS, 16'd1);
    repeat (2) add_event(KIND_TICK, 1'b1);
    add_event(KIND_POP, 1'b0);
    repeat (2) add_event(KIND_TICK, 1'b0);
    repeat (2) add_event(KIND_TICK, 1'b1);
    add_event(KIND_POP, 1'b1);
    wait_idle();
    gaps_on = 1'b1;

    write_reg(REG_DEBOUNCE_TICKS, 16'd5);
    write_reg(REG_MIN_PRESS_MS, 16'd8);
    add_random(40, 5);
    wait_idle();

    write_reg(REG_DEBOUNCE_TICKS, 16'd10);
    write_reg(REG_MIN_PRESS_MS, 16'd10);
    add_random(40, 10);
    wait_idle();
    repeat (8) @(negedge clk_i);

    if (error_count == 0 && expected_reports.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
